// ----- src/rfc_pkg.sv -----
// ----------------------------------------------------------------------------
// rfc_pkg
// shared types, register map and crc helper for the rtu response frame checker
// ----------------------------------------------------------------------------
package rfc_pkg;

    localparam int unsigned ADDR_W     = 5;
    localparam int unsigned MIN_FRAME  = 5;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam logic [7:0]  FUNC_MASK  = 8'h7F;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    typedef enum logic [2:0] {
        REG_CHECK_UNIT       = 3'd0,
        REG_CHECK_FUNCTION   = 3'd1,
        REG_EXPECTED_UNIT    = 3'd2,
        REG_REQUEST_FUNCTION = 3'd3,
        REG_MAX_PDU_LENGTH   = 3'd4
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_SHORT = 3'd1,
        ST_CRC_ERR   = 3'd2,
        ST_BAD_RESP  = 3'd3,
        ST_EXCEPTION = 3'd4,
        ST_TOO_LONG  = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } item_t;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] pdu_byte;
        logic [2:0] status;
        logic [7:0] unit_seen;
        logic [6:0] function_seen;
        logic [7:0] exc_code;
        logic [7:0] pdu_length;
        logic       last_item;
    } result_t;

    typedef struct packed {
        logic       check_unit;
        logic       check_function;
        logic [7:0] expected_unit;
        logic [7:0] request_function;
        logic [7:0] max_pdu_length;
    } cfg_t;

    // up to two results per accepted byte, written in order
    typedef struct packed {
        logic    v0;
        result_t d0;
        logic    v1;
        result_t d1;
    } push_t;

    // bytewise crc-16 update, reflected polynomial
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- src/rtu_response_frame_checker_unit.sv -----
// ----------------------------------------------------------------------------
// rtu_response_frame_checker_unit
// checks a received rtu response frame byte by byte and reports its status
// ----------------------------------------------------------------------------
//  channel   direction  handshake                      payload
//  item      in         item_valid / item_ready        item_t (rx_byte, frame_end)
//  result    out        result_valid / result_ready    result_t
//  config    in         apb psel/penable/pwrite/pready 32-bit registers at 4*i
//
//  one byte is taken per cycle unless stalled; it is held in the input
//  register, then the pdu byte from two bytes back and, on frame end, the
//  status item enter a four-entry queue; a byte with both results fills two
//  entries; the input stalls only while the queue has fewer than two free
//  entries; reset clears the frame state and queue; no clearing pass is needed
// ----------------------------------------------------------------------------
module rtu_response_frame_checker_unit #(
    parameter int MAX_FRAME = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  rfc_pkg::item_t             item_data,
    output logic                       result_valid,
    input  logic                       result_ready,
    output rfc_pkg::result_t           result_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rfc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import rfc_pkg::*;

    cfg_t  cfg;
    push_t push;
    logic  room;

    rfc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rfc_core #(
        .MAX_FRAME (MAX_FRAME)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_data  (item_data),
        .cfg        (cfg),
        .room       (room),
        .push       (push)
    );

    rfc_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room         (room),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

endmodule

// ----- src/rfc_regs.sv -----
// ----------------------------------------------------------------------------
// rfc_regs
// apb register file holding the checker configuration
// ----------------------------------------------------------------------------
module rfc_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rfc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output rfc_pkg::cfg_t              cfg
);
    import rfc_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] idx;

    assign idx    = paddr[ADDR_W-1:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_CHECK_UNIT:       cfg_next.check_unit       = pwdata[0];
                REG_CHECK_FUNCTION:   cfg_next.check_function   = pwdata[0];
                REG_EXPECTED_UNIT:    cfg_next.expected_unit    = pwdata[7:0];
                REG_REQUEST_FUNCTION: cfg_next.request_function = pwdata[7:0];
                REG_MAX_PDU_LENGTH:   cfg_next.max_pdu_length   = pwdata[7:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_CHECK_UNIT:       prdata = {31'd0, cfg_reg.check_unit};
            REG_CHECK_FUNCTION:   prdata = {31'd0, cfg_reg.check_function};
            REG_EXPECTED_UNIT:    prdata = {24'd0, cfg_reg.expected_unit};
            REG_REQUEST_FUNCTION: prdata = {24'd0, cfg_reg.request_function};
            REG_MAX_PDU_LENGTH:   prdata = {24'd0, cfg_reg.max_pdu_length};
            default:              prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.check_unit       <= 1'b0;
            cfg_reg.check_function   <= 1'b0;
            cfg_reg.expected_unit    <= 8'd1;
            cfg_reg.request_function <= 8'd3;
            cfg_reg.max_pdu_length   <= 8'd253;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- src/rfc_core.sv -----
// ----------------------------------------------------------------------------
// rfc_core
// input register, frame state, crc and status evaluation
// ----------------------------------------------------------------------------
module rfc_core #(
    parameter int MAX_FRAME = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  rfc_pkg::item_t  item_data,
    input  rfc_pkg::cfg_t   cfg,
    input  logic            room,
    output rfc_pkg::push_t  push
);
    import rfc_pkg::*;

    localparam int CW = $clog2(MAX_FRAME + 2);
    localparam logic [CW-1:0] CNT_SAT = CW'(MAX_FRAME + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_FRAME);

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_end_reg;
    logic        advance;

    logic [15:0]   crc_reg, crc_next;
    logic [7:0]    older_reg, older_next;
    logic [7:0]    newer_reg, newer_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    unit_reg, unit_next;
    logic [7:0]    func_reg, func_next;
    logic [7:0]    third_reg, third_next;

    logic [15:0]   crc_cur;
    logic [7:0]    unit_cur, func_cur, third_cur;
    logic [CW-1:0] cnt_inc;
    logic [15:0]   n_wide, plen_wide;
    logic [15:0]   got;
    status_t       st;

    assign advance    = s1_valid_reg && room;
    assign item_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            s1_byte_reg <= item_data.rx_byte;
            s1_end_reg  <= item_data.frame_end;
        end
    end

    always_comb
    begin
        unit_cur  = (count_reg == CW'(0)) ? s1_byte_reg : unit_reg;
        func_cur  = (count_reg == CW'(1)) ? s1_byte_reg : func_reg;
        third_cur = (count_reg == CW'(2)) ? s1_byte_reg : third_reg;
        crc_cur   = (count_reg >= CW'(2)) ? crc16_feed(crc_reg, older_reg) : crc_reg;
        cnt_inc   = (count_reg < CNT_SAT) ? count_reg + CW'(1) : count_reg;
        n_wide    = 16'(cnt_inc);
        plen_wide = n_wide - 16'd3;
        // trailing two bytes, low byte first
        got       = {s1_byte_reg, newer_reg};

        priority if (n_wide < 16'(MIN_FRAME))
            st = ST_TOO_SHORT;
        else if (got != crc_cur)
            st = ST_CRC_ERR;
        else if (cfg.check_unit && (unit_cur != cfg.expected_unit))
            st = ST_BAD_RESP;
        else if (cfg.check_function && ((func_cur & FUNC_MASK) != cfg.request_function))
            st = ST_BAD_RESP;
        else if (func_cur[7])
            st = ST_EXCEPTION;
        else if ((cnt_inc > CNT_MAX) || (plen_wide > 16'(cfg.max_pdu_length)))
            st = ST_TOO_LONG;
        else
            st = ST_OK;
    end

    always_comb
    begin
        push = '0;
        push.v0          = advance && (count_reg >= CW'(3));
        push.d0.pdu_byte = older_reg;
        push.v1                   = advance && s1_end_reg;
        push.d1.item_kind         = 1'b1;
        push.d1.status            = st;
        push.d1.unit_seen         = unit_cur;
        push.d1.function_seen     = func_cur[6:0];
        push.d1.exc_code          = (st == ST_EXCEPTION) ? third_cur : 8'd0;
        push.d1.pdu_length        = (st == ST_OK) ? plen_wide[7:0] : 8'd0;
        push.d1.last_item         = 1'b1;
    end

    always_comb
    begin
        crc_next   = crc_reg;
        older_next = older_reg;
        newer_next = newer_reg;
        count_next = count_reg;
        unit_next  = unit_reg;
        func_next  = func_reg;
        third_next = third_reg;
        if (advance)
        begin
            if (s1_end_reg)
            begin
                crc_next   = CRC_INIT;
                older_next = 8'd0;
                newer_next = 8'd0;
                count_next = '0;
                unit_next  = 8'd0;
                func_next  = 8'd0;
                third_next = 8'd0;
            end
            else
            begin
                crc_next   = crc_cur;
                older_next = newer_reg;
                newer_next = s1_byte_reg;
                count_next = cnt_inc;
                unit_next  = unit_cur;
                func_next  = func_cur;
                third_next = third_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_INIT;
            older_reg <= 8'd0;
            newer_reg <= 8'd0;
            count_reg <= '0;
            unit_reg  <= 8'd0;
            func_reg  <= 8'd0;
            third_reg <= 8'd0;
        end
        else
        begin
            crc_reg   <= crc_next;
            older_reg <= older_next;
            newer_reg <= newer_next;
            count_reg <= count_next;
            unit_reg  <= unit_next;
            func_reg  <= func_next;
            third_reg <= third_next;
        end
    end

endmodule

// ----- src/rfc_fifo.sv -----
// ----------------------------------------------------------------------------
// rfc_fifo
// small result queue taking up to two results per cycle, one out per cycle while ready
// ----------------------------------------------------------------------------
module rfc_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  rfc_pkg::push_t   push,
    output logic             room,
    output logic             result_valid,
    input  logic             result_ready,
    output rfc_pkg::result_t result_data
);
    import rfc_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    result_t       mem_reg [FIFO_DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] wr_second;
    logic          pop;

    assign room         = count_reg <= CW'(FIFO_DEPTH - 2);
    assign result_valid = count_reg != '0;
    assign result_data  = mem_reg[rd_reg];
    assign pop          = result_valid && result_ready;
    assign wr_second    = wr_reg + PW'(push.v0);

    always_comb
    begin
        wr_next    = wr_reg + PW'(push.v0) + PW'(push.v1);
        rd_next    = rd_reg + PW'(pop);
        count_next = count_reg + CW'(push.v0) + CW'(push.v1) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            mem_reg[wr_reg] <= push.d0;
        end
        if (push.v1)
        begin
            mem_reg[wr_second] <= push.d1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- tb/sv/rtu_response_frame_checker_unit_test.sv -----
// ----------------------------------------------------------------------------
// rtu_response_frame_checker_unit_test
// drives rtu response frames byte by byte through the frame checker, predicts
// every pdu byte and frame status, and compares each result transaction in
// order while the register settings change between phases
// ----------------------------------------------------------------------------
module rtu_response_frame_checker_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import rfc_pkg::*;

    localparam int          FRAME_LIMIT = 256;
    localparam int          ITEM_TARGET = 1500;
    localparam int          PHASE_BYTES = 140;
    localparam int          SETTLE      = 8;
    localparam int          CYCLE_LIMIT = 500000;
    localparam logic [2:0]  UNUSED_REG  = 3'd5;

    class frame_scoreboard;
        logic        chk_unit;
        logic        chk_func;
        logic [7:0]  exp_unit;
        logic [7:0]  req_func;
        logic [7:0]  max_pdu;
        logic [15:0] crc;
        logic [7:0]  older;
        logic [7:0]  newer;
        int unsigned count;
        logic [7:0]  unit_b;
        logic [7:0]  func_b;
        logic [7:0]  third_b;
        result_t     pending[$];
        int          errors;

        function new();
            chk_unit = 1'b0;
            chk_func = 1'b0;
            exp_unit = 8'd1;
            req_func = 8'd3;
            max_pdu  = 8'd253;
            errors   = 0;
            clear_frame();
        endfunction

        static function logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
            logic [15:0] c;
            c = acc ^ {8'h00, b};
            for (int k = 0; k < 8; k++)
            begin
                if (c[0])
                    c = (c >> 1) ^ 16'hA001;
                else
                    c = c >> 1;
            end
            return c;
        endfunction

        function void clear_frame();
            crc     = 16'hFFFF;
            older   = 8'h00;
            newer   = 8'h00;
            count   = 0;
            unit_b  = 8'h00;
            func_b  = 8'h00;
            third_b = 8'h00;
        endfunction

        function void write_reg(input logic [2:0] idx, input logic [31:0] data);
            case (idx)
                REG_CHECK_UNIT:       chk_unit = data[0];
                REG_CHECK_FUNCTION:   chk_func = data[0];
                REG_EXPECTED_UNIT:    exp_unit = data[7:0];
                REG_REQUEST_FUNCTION: req_func = data[7:0];
                REG_MAX_PDU_LENGTH:   max_pdu  = data[7:0];
                default: ;
            endcase
        endfunction

        // one accepted byte: pdu byte from two back, and status on frame end
        function void note_byte(input item_t it);
            result_t     r;
            status_t     st;
            int unsigned n;
            logic [15:0] got;
            if (count == 0)
                unit_b = it.rx_byte;
            else if (count == 1)
                func_b = it.rx_byte;
            else if (count == 2)
                third_b = it.rx_byte;
            if (count >= 2)
            begin
                crc = crc16_step(crc, older);
                if (count >= 3)
                begin
                    r = '0;
                    r.pdu_byte = older;
                    pending.push_back(r);
                end
            end
            older = newer;
            newer = it.rx_byte;
            if (count < FRAME_LIMIT + 1)
                count++;
            if (it.frame_end)
            begin
                n   = count;
                got = {it.rx_byte, older};
                r   = '0;
                r.item_kind     = 1'b1;
                r.last_item     = 1'b1;
                r.unit_seen     = unit_b;
                r.function_seen = func_b[6:0];
                if (n < 5)
                    st = ST_TOO_SHORT;
                else if (got != crc)
                    st = ST_CRC_ERR;
                else if (chk_unit && unit_b != exp_unit)
                    st = ST_BAD_RESP;
                else if (chk_func && {1'b0, func_b[6:0]} != req_func)
                    st = ST_BAD_RESP;
                else if (func_b[7])
                begin
                    st = ST_EXCEPTION;
                    r.exc_code = third_b;
                end
                else if (n > FRAME_LIMIT || n - 3 > max_pdu)
                    st = ST_TOO_LONG;
                else
                begin
                    st = ST_OK;
                    r.pdu_length = 8'(n - 3);
                end
                r.status = st;
                pending.push_back(r);
                clear_frame();
            end
        endfunction

        function void compare_field(input string name, input logic [7:0] e, input logic [7:0] a);
            if (a !== e)
            begin
                $error("%s mismatch: expected %0h actual %0h", name, e, a);
                errors++;
            end
        endfunction

        function void check_result(input result_t a);
            result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result transaction %0h", a);
                errors++;
                return;
            end
            e = pending.pop_front();
            compare_field("item_kind", 8'(e.item_kind), 8'(a.item_kind));
            compare_field("pdu_byte", e.pdu_byte, a.pdu_byte);
            compare_field("status", 8'(e.status), 8'(a.status));
            compare_field("unit_seen", e.unit_seen, a.unit_seen);
            compare_field("function_seen", 8'(e.function_seen), 8'(a.function_seen));
            compare_field("exc_code", e.exc_code, a.exc_code);
            compare_field("pdu_length", e.pdu_length, a.pdu_length);
            compare_field("last_item", 8'(e.last_item), 8'(a.last_item));
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                item_valid;
    logic                item_ready;
    item_t               item_data;
    logic                result_valid;
    logic                result_ready;
    result_t             result_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    frame_scoreboard book;
    bit              idle_on;
    int              stall_left;
    int              total_bytes;
    int              cycles;

    rtu_response_frame_checker_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // transaction monitor and run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else if (rst_n)
        begin
            if (item_valid && item_ready)
                book.note_byte(item_data);
            if (result_valid && result_ready)
                book.check_result(result_data);
        end
    end

    // receiver backpressure in short bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            result_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 3);
            result_ready <= 1'b0;
        end
        else
            result_ready <= 1'b1;
    end

    task automatic apb_write(input logic [2:0] idx, input logic [7:0] value);
        logic [31:0] data;
        data = ($urandom() & 32'hFFFF_FF00) | {24'h0, value};
        if (idx == REG_CHECK_UNIT || idx == REG_CHECK_FUNCTION)
            data = ($urandom() & 32'hFFFF_FFFE) | {31'h0, value[0]};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        book.write_reg(idx, data);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic cu, input logic cf, input logic [7:0] eu,
                              input logic [7:0] rf, input logic [7:0] mx);
        apb_write(REG_CHECK_UNIT, {7'h0, cu});
        apb_write(REG_CHECK_FUNCTION, {7'h0, cf});
        apb_write(REG_EXPECTED_UNIT, eu);
        apb_write(REG_REQUEST_FUNCTION, rf);
        apb_write(REG_MAX_PDU_LENGTH, mx);
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        item_data  <= '{rx_byte: b, frame_end: last};
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        total_bytes++;
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [7:0] unit, input logic [7:0] func,
                              input int data_len, input bit corrupt);
        logic [7:0]  frame_q[$];
        logic [15:0] crc;
        frame_q = {};
        frame_q.push_back(unit);
        frame_q.push_back(func);
        repeat (data_len)
            frame_q.push_back(8'($urandom()));
        crc = 16'hFFFF;
        foreach (frame_q[i])
            crc = frame_scoreboard::crc16_step(crc, frame_q[i]);
        if (corrupt)
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        frame_q.push_back(crc[7:0]);
        frame_q.push_back(crc[15:8]);
        foreach (frame_q[i])
            send_byte(frame_q[i], i == frame_q.size() - 1);
    endtask

    task automatic send_noise(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom()), i == len - 1);
    endtask

    task automatic random_frame();
        int         pick;
        int         data_len;
        logic [7:0] unit;
        logic [7:0] func;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            send_noise($urandom_range(1, 8));
        else
        begin
            unit = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : book.exp_unit;
            pick = $urandom_range(0, 99);
            if (pick < 60)
                func = book.req_func[7] ? 8'($urandom_range(0, 127)) : book.req_func;
            else if (pick < 75)
                func = {1'b1, book.req_func[6:0]};
            else
                func = 8'($urandom());
            pick = $urandom_range(0, 99);
            if (pick < 96)
                data_len = $urandom_range(0, 12);
            else if (pick < 99)
                data_len = $urandom_range(13, 252);
            else
                data_len = $urandom_range(253, 256);
            send_frame(unit, func, data_len, $urandom_range(0, 7) == 0);
        end
    endtask

    // idle wait until every expected transaction is back
    task automatic drain();
        item_valid <= 1'b0;
        while (book.pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    initial
    begin
        int phase;
        int start;
        book        = new();
        idle_on     = 1'b1;
        stall_left  = 0;
        total_bytes = 0;
        cycles      = 0;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item_data    = '0;
        result_ready = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed frames under reset settings
        send_noise(1);
        send_frame(8'h01, 8'h03, 0, 1'b0);
        send_frame(8'h01, 8'h03, 1, 1'b0);
        send_frame(8'h01, 8'h03, 1, 1'b1);
        send_frame(8'h01, 8'h83, 1, 1'b0);
        send_frame(8'hFF, 8'hFF, 1, 1'b0);
        send_frame(8'h00, 8'h00, 2, 1'b0);
        drain();

        phase = 0;
        while (total_bytes < ITEM_TARGET)
        begin
            phase++;
            idle_on = total_bytes < ITEM_TARGET * 3 / 4;
            case (phase)
                1: set_config(1'b1, 1'b1, 8'h00, 8'h00, 8'd253);
                2: set_config(1'b1, 1'b1, 8'hFF, 8'hFF, 8'd0);
                3: set_config(1'($urandom()), 1'($urandom()), 8'($urandom()), 8'h7F, 8'd253);
                default:
                    set_config(1'($urandom()), 1'($urandom()), 8'($urandom()),
                               ($urandom_range(0, 3) == 0) ? 8'($urandom_range(128, 255))
                                                            : 8'($urandom_range(0, 127)),
                               ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 12))
                                                            : 8'($urandom_range(0, 253)));
            endcase
            if (phase == 1)
            begin
                // longest accepted frame, then one two bytes past the frame limit
                send_frame(8'h00, 8'h00, 252, 1'b0);
                send_frame(8'h00, 8'h00, 254, 1'b0);
            end
            if (phase == 3)
                apb_write(UNUSED_REG, 8'($urandom()));
            start = total_bytes;
            while (total_bytes - start < PHASE_BYTES)
                random_frame();
            drain();
        end

        if (book.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
